[rtl/mst_pkg.sv]
// Shared types and constants for the Prim minimum spanning tree block.
// No dependencies; compiled first.
package mst_pkg;

  // Fixed field widths of the load, result and setup channels
  localparam int VERTEX_FIELD_BITS = 4;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int COUNT_BITS        = 5;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RESET = 5'd16;
  localparam int                    MIN_VERTICES       = 2;
  localparam int                    FIELD_VERTEX_LIMIT = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SETTLE,
    ST_PICK,
    ST_OUT_ADDR,
    ST_OUT_PARENT,
    ST_OUT_FORM
  } state_t;

endpackage

[rtl/mst_if.sv]
// Valid/ready channel interfaces for the load, result and setup ports.
// Depends on mst_pkg for field widths.
interface mst_load_if;
  logic                                   valid;
  logic                                   ready;
  logic [mst_pkg::VERTEX_FIELD_BITS-1:0]  row_vertex;
  logic [mst_pkg::VERTEX_FIELD_BITS-1:0]  column_vertex;
  logic [mst_pkg::WEIGHT_FIELD_BITS-1:0]  edge_weight;
  logic                                   last_entry;

  modport source (output valid, row_vertex, column_vertex, edge_weight, last_entry,
                  input ready);
  modport sink   (input valid, row_vertex, column_vertex, edge_weight, last_entry,
                  output ready);
endinterface

interface mst_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [mst_pkg::VERTEX_FIELD_BITS-1:0]  vertex;
  logic [mst_pkg::VERTEX_FIELD_BITS-1:0]  parent_vertex;
  logic [mst_pkg::WEIGHT_FIELD_BITS-1:0]  tree_weight;
  logic                                   reachable;
  logic                                   last_result;

  modport source (output valid, vertex, parent_vertex, tree_weight, reachable, last_result,
                  input ready);
  modport sink   (input valid, vertex, parent_vertex, tree_weight, reachable, last_result,
                  output ready);
endinterface

interface mst_setup_if;
  logic                            valid;
  logic                            ready;
  logic [mst_pkg::COUNT_BITS-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/minimum_spanning_tree_prim.sv]
// Prim minimum spanning tree over a loaded adjacency matrix.
// Sequence: the last load starts n-1 passes, each a sweep with one matrix/key read per
// vertex through one compare unit, then settle and pick. Each of the n-1 results steps
// through address, parent and form states and waits out any output stall. Load ready is
// low from the last load until the final result sits in the output register.
// Reset: synchronous; clears control, sets vertex_count to 16; the matrix is not cleared.
module minimum_spanning_tree_prim #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  mst_load_if.sink     load,
  mst_result_if.source result,
  mst_setup_if.sink    setup
);

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int KW    = WEIGHT_BITS + 1;
  localparam int N_TOP = (MAX_VERTICES < mst_pkg::FIELD_VERTEX_LIMIT) ?
                         MAX_VERTICES : mst_pkg::FIELD_VERTEX_LIMIT;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  mst_pkg::state_t state, state_next;

  logic [mst_pkg::COUNT_BITS-1:0] vertex_count;
  logic [CW-1:0]                  n_active, n_clamped;
  logic [CW-1:0]                  v, pass_cnt;
  logic [VB-1:0]                  u, u_pick;
  logic                           first_pass;
  logic [MAX_VERTICES-1:0]        visited;

  // compare stage of the sweep
  logic                           pv;
  logic [VB-1:0]                  vb;
  logic [WEIGHT_BITS-1:0]         w;
  logic                           vis, lower;
  logic [KW-1:0]                  key_old, key_new;

  // running pick for the next pass
  logic [VB-1:0]                  best, first_free;
  logic                           best_found, free_found;
  logic [KW-1:0]                  least;

  // storage
  logic [WEIGHT_BITS-1:0] matrix [MAX_VERTICES][MAX_VERTICES];
  logic [KW-1:0]          key_mem [MAX_VERTICES];
  logic [VB-1:0]          parent_mem [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] mat_q;
  logic [KW-1:0]          key_q;
  logic [VB-1:0]          par_q;
  logic [VB-1:0]          rd_row, rd_col, st_addr;

  logic                   load_fire, load_in_range, res_free, res_reached, last_vertex;
  logic [VB-1:0]          load_row, load_col;

  // output register
  logic                                  res_valid;
  logic [mst_pkg::VERTEX_FIELD_BITS-1:0] res_vertex, res_parent;
  logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] res_weight;
  logic                                  res_reachable, res_last;

  assign setup.ready = 1'b1;
  assign load_fire   = load.valid && load.ready;
  assign load_row    = VB'(load.row_vertex);
  assign load_col    = VB'(load.column_vertex);
  assign load_in_range = (int'(load.row_vertex) < MAX_VERTICES) &&
                         (int'(load.column_vertex) < MAX_VERTICES);

  assign res_free    = !res_valid || result.ready;
  assign last_vertex = (v == n_active - CW'(1));

  always_comb begin
    if (int'(vertex_count) < mst_pkg::MIN_VERTICES) begin
      n_clamped = CW'(mst_pkg::MIN_VERTICES);
    end else if (int'(vertex_count) > N_TOP) begin
      n_clamped = CW'(N_TOP);
    end else begin
      n_clamped = CW'(vertex_count);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load.ready = 1'b0;
    case (state)
      mst_pkg::ST_IDLE: begin
        load.ready = 1'b1;
        if (load.valid && load.last_entry) begin
          state_next = mst_pkg::ST_SWEEP;
        end
      end
      mst_pkg::ST_SWEEP: begin
        if (last_vertex) begin
          state_next = mst_pkg::ST_SETTLE;
        end
      end
      mst_pkg::ST_SETTLE: state_next = mst_pkg::ST_PICK;
      mst_pkg::ST_PICK: begin
        if (pass_cnt + CW'(1) == n_active - CW'(1)) begin
          state_next = mst_pkg::ST_OUT_ADDR;
        end else begin
          state_next = mst_pkg::ST_SWEEP;
        end
      end
      mst_pkg::ST_OUT_ADDR:   state_next = mst_pkg::ST_OUT_PARENT;
      mst_pkg::ST_OUT_PARENT: state_next = mst_pkg::ST_OUT_FORM;
      mst_pkg::ST_OUT_FORM: begin
        if (res_free) begin
          state_next = last_vertex ? mst_pkg::ST_IDLE : mst_pkg::ST_OUT_ADDR;
        end
      end
      default: state_next = mst_pkg::ST_IDLE;
    endcase
  end

  // Memory addressing: sweep reads row u, results read (v, parent of v)
  assign st_addr = v[VB-1:0];
  always_comb begin
    if (state == mst_pkg::ST_SWEEP) begin
      rd_row = u;
      rd_col = v[VB-1:0];
    end else begin
      rd_row = v[VB-1:0];
      rd_col = par_q;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire && load_in_range) begin
      matrix[load_row][load_col] <= WEIGHT_BITS'(load.edge_weight);
    end
    mat_q <= matrix[rd_row][rd_col];
  end

  // Compare stage: relax against u and track the next pick
  assign w       = mat_q;
  assign vis     = visited[vb];
  assign key_old = first_pass ? KEY_INF : key_q;
  assign lower   = (w != '0) && !vis && ({1'b0, w} < key_old);
  assign key_new = lower ? {1'b0, w} : key_old;

  always_ff @(posedge clk) begin
    if (pv) begin
      key_mem[vb] <= key_new;
      if (lower || first_pass) begin
        parent_mem[vb] <= u;
      end
    end
    key_q <= key_mem[st_addr];
    par_q <= parent_mem[st_addr];
  end

  always_comb begin
    if (best_found) begin
      u_pick = best;
    end else if (free_found) begin
      u_pick = first_free;
    end else begin
      u_pick = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mst_pkg::VERTEX_COUNT_RESET;
      pv           <= 1'b0;
    end else begin
      if (setup.valid && setup.ready) begin
        vertex_count <= setup.data;
      end
      pv <= (state == mst_pkg::ST_SWEEP);
    end
    vb <= v[VB-1:0];

    if (pv && !vis) begin
      if (!free_found) begin
        free_found <= 1'b1;
        first_free <= vb;
      end
      if (key_new < least) begin
        least      <= key_new;
        best       <= vb;
        best_found <= 1'b1;
      end
    end

    case (state)
      mst_pkg::ST_IDLE: begin
        if (load_fire && load.last_entry) begin
          n_active   <= n_clamped;
          u          <= '0;
          visited    <= MAX_VERTICES'(1);
          first_pass <= 1'b1;
          pass_cnt   <= '0;
          v          <= '0;
          best_found <= 1'b0;
          free_found <= 1'b0;
          least      <= KEY_INF;
        end
      end
      mst_pkg::ST_SWEEP: v <= v + CW'(1);
      mst_pkg::ST_PICK: begin
        pass_cnt <= pass_cnt + CW'(1);
        if (pass_cnt + CW'(1) == n_active - CW'(1)) begin
          v <= CW'(1);
        end else begin
          u           <= u_pick;
          visited[u_pick] <= 1'b1;
          first_pass  <= 1'b0;
          v           <= '0;
          best_found  <= 1'b0;
          free_found  <= 1'b0;
          least       <= KEY_INF;
        end
      end
      mst_pkg::ST_OUT_FORM: begin
        if (res_free) begin
          v <= v + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register; drop valid once the transfer completes
  assign res_reached = (key_q != KEY_INF);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == mst_pkg::ST_OUT_FORM && res_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (state == mst_pkg::ST_OUT_FORM && res_free) begin
      res_vertex    <= mst_pkg::VERTEX_FIELD_BITS'(v);
      res_parent    <= res_reached ? mst_pkg::VERTEX_FIELD_BITS'(par_q) : '0;
      res_weight    <= res_reached ? mst_pkg::WEIGHT_FIELD_BITS'(mat_q) : '0;
      res_reachable <= res_reached;
      res_last      <= last_vertex;
    end
  end

  assign result.valid         = res_valid;
  assign result.vertex        = res_vertex;
  assign result.parent_vertex = res_parent;
  assign result.tree_weight   = res_weight;
  assign result.reachable     = res_reachable;
  assign result.last_result   = res_last;

endmodule

[test/tb.sv]
// Testbench for minimum_spanning_tree_prim: loads adjacency matrices, solves them,
// checks every reported tree edge against a Prim predictor in this file or a hand-typed edge.
// Depends on rtl/mst_pkg.sv, rtl/mst_if.sv and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BITS      = mst_pkg::WEIGHT_FIELD_BITS + 1;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_LOADS  = 100;
  localparam int DIRECTED_ROWS = 22;
  localparam logic [KEY_BITS-1:0] KEY_INF = {1'b1, {mst_pkg::WEIGHT_FIELD_BITS{1'b0}}};

  typedef struct packed {
    logic [mst_pkg::VERTEX_FIELD_BITS-1:0] vertex;
    logic [mst_pkg::VERTEX_FIELD_BITS-1:0] parent_vertex;
    logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] tree_weight;
    logic                                  reachable;
    logic                                  last_result;
  } tree_edge_t;

  typedef enum logic {ROW_LOAD, ROW_COUNT} row_kind_t;
  typedef enum logic [1:0] {SHAPE_DENSE, SHAPE_SPARSE, SHAPE_TIES, SHAPE_EXTREME} shape_t;

  typedef struct packed {
    row_kind_t                             kind;
    logic [mst_pkg::COUNT_BITS-1:0]        count_value;
    logic [mst_pkg::VERTEX_FIELD_BITS-1:0] row_v;
    logic [mst_pkg::VERTEX_FIELD_BITS-1:0] col_v;
    logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] weight;
    logic                                  last;
    logic                                  typed;
    tree_edge_t                            hand_result;
  } plan_row_t;

  localparam tree_edge_t NO_RESULT = '0;

  logic clk;
  logic rst;

  mst_load_if   ld ();
  mst_result_if res ();
  mst_setup_if  setup_ch ();

  minimum_spanning_tree_prim uut (
    .clk    (clk),
    .rst    (rst),
    .load   (ld),
    .result (res),
    .setup  (setup_ch)
  );

  // Predictor state: matrix copy, which entries hold data, and the vertex count register
  logic [mst_pkg::WEIGHT_FIELD_BITS-1:0]
      weight_mem [mst_pkg::FIELD_VERTEX_LIMIT][mst_pkg::FIELD_VERTEX_LIMIT];
  bit                             loaded [mst_pkg::FIELD_VERTEX_LIMIT][mst_pkg::FIELD_VERTEX_LIMIT];
  logic [mst_pkg::COUNT_BITS-1:0] count_reg;
  tree_edge_t                     tree_edges_due [$];

  plan_row_t directed_plan [DIRECTED_ROWS];

  int  failures;
  int  mismatches;
  int  loads_sent;
  int  graphs_solved;
  int  edges_checked;
  int  random_loads;
  int  cycle_count;
  bit  no_gaps;
  bit  hold_armed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int used_vertices(logic [mst_pkg::COUNT_BITS-1:0] reg_value);
    int n;
    n = int'(reg_value);
    if (n < mst_pkg::MIN_VERTICES) n = mst_pkg::MIN_VERTICES;
    if (n > mst_pkg::FIELD_VERTEX_LIMIT) n = mst_pkg::FIELD_VERTEX_LIMIT;
    return n;
  endfunction

  // Grow the tree from vertex 0 and queue one edge per vertex 1..n-1
  function automatic void predict_tree();
    int                                    n, u, v, round, best, first_free;
    logic [KEY_BITS-1:0]                   least;
    logic [KEY_BITS-1:0]                   tree_key [mst_pkg::FIELD_VERTEX_LIMIT];
    bit                                    in_tree [mst_pkg::FIELD_VERTEX_LIMIT];
    logic [mst_pkg::VERTEX_FIELD_BITS-1:0] link [mst_pkg::FIELD_VERTEX_LIMIT];
    tree_edge_t                            found;
    n = used_vertices(count_reg);
    for (v = 0; v < mst_pkg::FIELD_VERTEX_LIMIT; v++) begin
      tree_key[v] = KEY_INF;
      in_tree[v]  = 1'b0;
      link[v]     = '0;
    end
    tree_key[0] = '0;
    for (round = 0; round + 1 < n; round++) begin
      best       = n;
      first_free = n;
      least      = KEY_INF;
      for (v = 0; v < n; v++) begin
        if (!in_tree[v]) begin
          if (first_free == n) first_free = v;
          if (tree_key[v] < least) begin
            least = tree_key[v];
            best  = v;
          end
        end
      end
      // nothing reachable left: take the lowest free vertex
      if (best == n) best = first_free;
      u = best;
      in_tree[u] = 1'b1;
      for (v = 0; v < n; v++) begin
        if (weight_mem[u][v] != '0 && !in_tree[v] && {1'b0, weight_mem[u][v]} < tree_key[v])
        begin
          link[v]     = u[mst_pkg::VERTEX_FIELD_BITS-1:0];
          tree_key[v] = {1'b0, weight_mem[u][v]};
        end
      end
    end
    for (v = 1; v < n; v++) begin
      found.vertex      = v[mst_pkg::VERTEX_FIELD_BITS-1:0];
      found.reachable   = (tree_key[v] != KEY_INF);
      found.parent_vertex = found.reachable ? link[v] : '0;
      found.tree_weight = found.reachable ? weight_mem[v][link[v]] : '0;
      found.last_result = (v + 1 == n);
      tree_edges_due.push_back(found);
    end
  endfunction

  function automatic logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] pick_weight(shape_t shape);
    logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] w;
    w = mst_pkg::WEIGHT_FIELD_BITS'($urandom_range(0, 65535));
    case (shape)
      SHAPE_DENSE:   if ($urandom_range(0, 7) == 0) w = '0;
      SHAPE_SPARSE:  if ($urandom_range(0, 99) < 65) w = '0;
      SHAPE_TIES:    w = mst_pkg::WEIGHT_FIELD_BITS'($urandom_range(0, 3));
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = 16'd1;
          2:       w = 16'hFFFE;
          default: w = 16'hFFFF;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // Offer one load, hold it until the transfer, then update the predictor
  task automatic send_load(input int row_v, input int col_v,
                           input logic [mst_pkg::WEIGHT_FIELD_BITS-1:0] weight,
                           input logic last, input logic typed, input tree_edge_t hand_result);
    while (!no_gaps && $urandom_range(0, 99) < 37) begin
      ld.valid <= 1'b0;
      @(posedge clk);
    end
    ld.valid         <= 1'b1;
    ld.row_vertex    <= row_v[mst_pkg::VERTEX_FIELD_BITS-1:0];
    ld.column_vertex <= col_v[mst_pkg::VERTEX_FIELD_BITS-1:0];
    ld.edge_weight   <= weight;
    ld.last_entry    <= last;
    do @(posedge clk); while (!ld.ready);
    weight_mem[row_v][col_v] = weight;
    loaded[row_v][col_v]     = 1'b1;
    loads_sent++;
    if (last) begin
      graphs_solved++;
      if (typed) tree_edges_due.push_back(hand_result);
      else predict_tree();
    end
  endtask

  // Change the vertex count only once the block has drained
  task automatic write_count(input logic [mst_pkg::COUNT_BITS-1:0] value);
    ld.valid <= 1'b0;
    while (tree_edges_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    setup_ch.valid <= 1'b1;
    setup_ch.data  <= value;
    do @(posedge clk); while (!setup_ch.ready);
    setup_ch.valid <= 1'b0;
    count_reg = value;
  endtask

  // One graph: fill whatever the active square still lacks, touch a few entries, solve
  task automatic solve_random_graph(input shape_t shape, input bit hold_results);
    int n, r, c, extra;
    n = used_vertices(count_reg);
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        if (!loaded[r][c]) begin
          send_load(r, c, pick_weight(shape), 1'b0, 1'b0, NO_RESULT);
          random_loads++;
        end
      end
    end
    extra = $urandom_range(1, 10);
    repeat (extra) begin
      send_load($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(shape), 1'b0,
                1'b0, NO_RESULT);
      random_loads++;
    end
    if ($urandom_range(0, 3) == 0) begin
      r = $urandom_range(0, mst_pkg::FIELD_VERTEX_LIMIT - 1);
      c = $urandom_range(0, mst_pkg::FIELD_VERTEX_LIMIT - 1);
    end else begin
      r = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
    end
    if (hold_results) hold_armed = 1'b1;
    send_load(r, c, pick_weight(shape), 1'b1, 1'b0, NO_RESULT);
    random_loads++;
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin : result_ready_drive
    int hold_left;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
        res.ready <= 1'b0;
      end else if (no_gaps) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  always @(posedge clk) begin : result_check
    tree_edge_t got, want;
    if (!rst && res.valid && res.ready) begin
      got.vertex        = res.vertex;
      got.parent_vertex = res.parent_vertex;
      got.tree_weight   = res.tree_weight;
      got.reachable     = res.reachable;
      got.last_result   = res.last_result;
      edges_checked++;
      if (tree_edges_due.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected tree edge: vertex %0d parent %0d weight %0d reach %0b last %0b",
                   got.vertex, got.parent_vertex, got.tree_weight, got.reachable,
                   got.last_result);
      end else begin
        want = tree_edges_due.pop_front();
        if (got.vertex !== want.vertex || got.parent_vertex !== want.parent_vertex ||
            got.tree_weight !== want.tree_weight || got.reachable !== want.reachable ||
            got.last_result !== want.last_result) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("edge mismatch: want v%0d p%0d w%0d r%0b l%0b, got v%0d p%0d w%0d r%0b l%0b",
                     want.vertex, want.parent_vertex, want.tree_weight, want.reachable,
                     want.last_result, got.vertex, got.parent_vertex, got.tree_weight,
                     got.reachable, got.last_result);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d edges still due", cycle_count,
             tree_edges_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int     idx, graph_i;
    int     fixed_counts [$];
    logic [mst_pkg::COUNT_BITS-1:0] count_value;
    failures       = 0;
    mismatches     = 0;
    loads_sent     = 0;
    graphs_solved  = 0;
    edges_checked  = 0;
    random_loads   = 0;
    no_gaps        = 1'b0;
    hold_armed     = 1'b0;
    count_reg      = mst_pkg::VERTEX_COUNT_RESET;
    for (int r = 0; r < mst_pkg::FIELD_VERTEX_LIMIT; r++)
      for (int c = 0; c < mst_pkg::FIELD_VERTEX_LIMIT; c++) begin
        weight_mem[r][c] = '0;
        loaded[r][c]     = 1'b0;
      end
    rst              <= 1'b1;
    ld.valid         <= 1'b0;
    ld.row_vertex    <= '0;
    ld.column_vertex <= '0;
    ld.edge_weight   <= '0;
    ld.last_entry    <= 1'b0;
    setup_ch.valid   <= 1'b0;
    setup_ch.data    <= '0;

    // kind, count, row, column, weight, last, typed, expected edge
    directed_plan = '{
      '{ROW_COUNT, 5'd2,  4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd1, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd0, 16'h1234, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd1, 16'h0007, 1'b1, 1'b1,
        '{4'd1, 4'd0, 16'h1234, 1'b1, 1'b1}},
      // edge 0->1 removed: vertex 1 never reached
      '{ROW_LOAD,  5'd0,  4'd0, 4'd1, 16'h0000, 1'b1, 1'b1,
        '{4'd1, 4'd0, 16'h0000, 1'b0, 1'b1}},
      // count below range clamps to two
      '{ROW_COUNT, 5'd0,  4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd1, 16'h0001, 1'b1, 1'b1,
        '{4'd1, 4'd0, 16'h1234, 1'b1, 1'b1}},
      '{ROW_COUNT, 5'd1,  4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd0, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd1, 16'hFFFF, 1'b1, 1'b1,
        '{4'd1, 4'd0, 16'hFFFF, 1'b1, 1'b1}},
      // three vertices: equal keys, a tie that does not relax, then a disconnected vertex
      '{ROW_COUNT, 5'd3,  4'd0, 4'd0, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd2, 16'h0005, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd1, 16'h0005, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd2, 16'h0005, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd1, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd2, 4'd0, 16'h0009, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd2, 4'd1, 16'h0003, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd2, 4'd2, 16'h0000, 1'b1, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd0, 4'd2, 16'h0000, 1'b0, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd2, 16'h0000, 1'b1, 1'b0, NO_RESULT},
      '{ROW_LOAD,  5'd0,  4'd1, 4'd2, 16'h0002, 1'b1, 1'b0, NO_RESULT}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
      if (directed_plan[idx].kind == ROW_COUNT)
        write_count(directed_plan[idx].count_value);
      else
        send_load(directed_plan[idx].row_v, directed_plan[idx].col_v,
                  directed_plan[idx].weight, directed_plan[idx].last,
                  directed_plan[idx].typed, directed_plan[idx].hand_result);
    end

    // First setting runs with no gaps; the hold-off lands on the second setting
    fixed_counts = '{6, 8, 1, 4};
    idx = 0;
    while (idx < fixed_counts.size() || random_loads < RANDOM_LOADS) begin
      if (idx < fixed_counts.size()) count_value = mst_pkg::COUNT_BITS'(fixed_counts[idx]);
      else count_value = mst_pkg::COUNT_BITS'($urandom_range(0, 8));
      write_count(count_value);
      no_gaps = (idx == 0);
      for (graph_i = 0; graph_i < 2; graph_i++)
        solve_random_graph(shape_t'($urandom_range(0, 3)), idx == 1 && graph_i == 0);
      no_gaps = 1'b0;
      idx++;
    end

    ld.valid <= 1'b0;
    while (tree_edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += tree_edges_due.size();

    $display("solved %0d graphs from %0d matrix loads, %0d tree edges checked",
             graphs_solved, loads_sent, edges_checked);
    $display("vertex counts from the clamped floor up to eight, %0d mismatches",
             mismatches);
    if (failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
